// ----- hdl/gbc_pkg.sv -----
// gbc_pkg: widths, register indexes and shared types of the gammatone cascade.
// No dependencies; used by gbc_cell and gammatone_biquad_cascade.
package gbc_pkg;

    localparam int SAMPLE_W     = 16;                     // input sample, Q1.15
    localparam int COEF_W       = 48;                     // coefficients and state, Q16.32
    localparam int COEF_FRAC    = 32;
    localparam int OUT_W        = 24;                     // output sample, Q9.15
    localparam int OUT_FRAC     = 15;
    localparam int NUM_REGS     = 8;
    localparam int NUM_SECTIONS = 4;
    localparam int CFG_IDX_W    = 4;
    localparam int REG_IDX_W    = $clog2(NUM_REGS);

    localparam int SAMPLE_SHIFT = COEF_FRAC - (SAMPLE_W - 1);
    localparam int OUT_SHIFT    = COEF_FRAC - OUT_FRAC;
    localparam int HALF_W       = COEF_W / 2;             // data split for partial products
    localparam int PROD_W       = COEF_W + HALF_W + 1;    // coef x (half + sign) product
    localparam int ACC_W        = 2 * COEF_W + 4;         // four full products plus margin

    // rounding constant, half of one Q.32 LSB in the Q.64 sum
    localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(64'd1 << (COEF_FRAC - 1));

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_FIRST_TAP0  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_FIRST_TAP1  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_PLAIN_TAP0  = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_SECOND_TAP1 = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_THIRD_TAP1  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_FOURTH_TAP1 = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_FEEDBACK1   = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_FEEDBACK2   = REG_IDX_W'(7);

    typedef logic signed [COEF_W-1:0] t_coef;

    // coefficient set seen by one section cell
    typedef struct packed {
        t_coef tap0;
        t_coef tap1;
        t_coef fb1;
        t_coef fb2;
    } t_coefs;

endpackage

// ----- hdl/gbc_cell.sv -----
// gbc_cell: one direct-form-I biquad section of the cascade.
// Holds its own input and output history; one 48 x 25 multiplier, eight passes.
// Depends on gbc_pkg.
module gbc_cell
    import gbc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_coefs i_coef,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_coef  i_in_data,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_coef  o_out_data
);

    localparam logic [1:0] PRD_FWD  = 2'd0;   // tap0 * u[n]
    localparam logic [1:0] PRD_HIST = 2'd1;   // tap1 * u[n-1]
    localparam logic [1:0] PRD_FB1  = 2'd2;   // -fb1 * y[n-1]
    localparam logic [1:0] PRD_FB2  = 2'd3;   // -fb2 * y[n-2]
    localparam logic [2:0] CNT_LAST = 3'd7;
    localparam int         HI_W     = ACC_W - COEF_FRAC;

    // history
    t_coef r_u0, r_x1, r_y1, r_y2;

    // sequencer
    logic       r_issue;
    logic [2:0] r_cnt;
    logic       r_out_vld;

    // product stage
    logic                     r_pvld, r_pfirst, r_plast, r_pshift, r_pneg;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]         r_acc;

    logic                     w_accept, w_finish, w_neg;
    logic [1:0]               w_sel;
    t_coef                    w_a, w_b;
    logic signed [HALF_W:0]   w_bpart;
    logic signed [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]         w_term_lo, w_term, w_addend, w_base, w_sum;
    logic [HI_W-1:0]          w_hi;
    logic                     w_fits;
    t_coef                    w_y;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_finish    = r_pvld && r_plast;
    assign o_in_ready  = !r_issue && !r_pvld && (!r_out_vld || i_out_ready);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_y1;

    // operand select
    assign w_sel = r_cnt[2:1];
    always_comb begin
        case (w_sel)
            PRD_FWD: begin
                w_a = i_coef.tap0;
                w_b = r_u0;
            end
            PRD_HIST: begin
                w_a = i_coef.tap1;
                w_b = r_x1;
            end
            PRD_FB1: begin
                w_a = i_coef.fb1;
                w_b = r_y1;
            end
            PRD_FB2: begin
                w_a = i_coef.fb2;
                w_b = r_y2;
            end
            default: begin
                w_a = i_coef.tap0;
                w_b = r_u0;
            end
        endcase
    end

    assign w_neg   = (w_sel == PRD_FB1) || (w_sel == PRD_FB2);
    // low half is unsigned, high half carries the sign
    assign w_bpart = r_cnt[0] ? $signed({w_b[COEF_W-1], w_b[COEF_W-1:HALF_W]})
                              : $signed({1'b0, w_b[HALF_W-1:0]});
    assign w_prod  = w_a * w_bpart;

    // accumulate; rounding constant preloaded with the first term
    assign w_term_lo = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_term    = r_pshift ? (w_term_lo << HALF_W) : w_term_lo;
    assign w_addend  = r_pneg ? ~w_term : w_term;
    assign w_base    = r_pfirst ? ACC_HALF : r_acc;
    assign w_sum     = w_base + w_addend + {{(ACC_W-1){1'b0}}, r_pneg};

    // drop Q.32 fraction, saturate to coefficient width
    assign w_hi   = w_sum[ACC_W-1:COEF_FRAC];
    assign w_fits = (&w_hi[HI_W-1:COEF_W-1]) || !(|w_hi[HI_W-1:COEF_W-1]);
    assign w_y    = w_fits ? $signed(w_hi[COEF_W-1:0])
                  : (w_sum[ACC_W-1] ? $signed({1'b1, {(COEF_W-1){1'b0}}})
                                    : $signed({1'b0, {(COEF_W-1){1'b1}}}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
            r_pvld    <= 1'b0;
            r_plast   <= 1'b0;
            r_u0      <= '0;
            r_x1      <= '0;
            r_y1      <= '0;
            r_y2      <= '0;
        end else begin
            if (w_accept) begin
                r_issue <= 1'b1;
                r_cnt   <= '0;
                r_x1    <= r_u0;
                r_u0    <= i_in_data;
            end else if (r_issue) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == CNT_LAST) begin
                    r_issue <= 1'b0;
                end
            end
            r_pvld  <= r_issue;
            r_plast <= r_issue && (r_cnt == CNT_LAST);
            if (w_finish) begin
                r_y1      <= w_y;
                r_y2      <= r_y1;
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= w_prod;
        r_pfirst <= (r_cnt == 3'd0);
        r_pshift <= r_cnt[0];
        r_pneg   <= w_neg;
        if (r_pvld) begin
            r_acc <= w_sum;
        end
    end

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_issue |-> r_cnt == 3'd0)
        else $error("cell counter moved while not issuing");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_issue && r_cnt == 3'd0)
        else $error("accepted request did not start a pass");

    a_finish_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> !r_issue && !o_in_ready)
        else $error("section finished while still issuing");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_finish))
        else $error("section result appeared without a finished pass");

endmodule

// ----- hdl/gammatone_biquad_cascade.sv -----
// gammatone_biquad_cascade: top level of one gammatone filter bank channel.
// Holds the coefficient registers, the chain of four gbc_cell sections and the
// output rounding stage. Depends on gbc_pkg and gbc_cell.

// One channel of a fourth-order ERB gammatone filter: each 16-bit Q1.15 sample
// is scaled to Q.32 and runs through four direct-form-I biquad cells in a row,
// then section four's Q.32 output is rounded half up to Q9.15 and saturated to
// 24 bits. Coefficients are 48-bit signed Q16.32 words written over the config
// port (index 0..7 as listed below; any higher index is ignored, and the port
// is always ready). Write them only while the filter is empty. Every cell runs
// one 48 x 25 multiplier through eight partial products plus one final
// accumulate, and takes no new sample until it is done with the last one. The
// cells are pipelined, so the four sections work on different samples at once.
// A finished result waits in the output register while the cells keep working.
//   0 first_gain_tap0   1 first_gain_tap1   2 plain_tap0   3 second_tap1
//   4 third_tap1        5 fourth_tap1       6 feedback_one 7 feedback_two
module gammatone_biquad_cascade
    import gbc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config request channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic signed [COEF_W-1:0]    i_cfg_data,
    // sample in
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [SAMPLE_W-1:0]  i_sample_in,
    // sample out
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [OUT_W-1:0]     o_sample_out
);

    localparam int Q_W = COEF_W - OUT_SHIFT + 1;

    // coefficient registers, each read at fixed places only
    t_coef r_cfg [NUM_REGS];

    // handshake chain between cells; slot 0 is the sample input
    logic   w_vld [NUM_SECTIONS+1];
    logic   w_rdy [NUM_SECTIONS+1];
    t_coef  w_dat [NUM_SECTIONS+1];
    t_coefs w_coef [NUM_SECTIONS];

    logic                    r_out_vld;
    logic signed [OUT_W-1:0] r_sample_out;

    logic                    w_take;
    logic signed [Q_W-1:0]   w_q;
    logic                    w_q_fits;
    logic signed [OUT_W-1:0] w_out;

    // config writes; out-of-range indexes drop
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            r_cfg[i_cfg_index[REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // sample to Q.32
    assign w_vld[0]   = i_in_valid;
    assign o_in_ready = w_rdy[0];
    assign w_dat[0]   = {{(COEF_W-SAMPLE_W-SAMPLE_SHIFT){i_sample_in[SAMPLE_W-1]}},
                         i_sample_in, {SAMPLE_SHIFT{1'b0}}};

    // section one has the gain folded in; the rest share plain_tap0
    assign w_coef[0] = '{tap0: r_cfg[REG_FIRST_TAP0], tap1: r_cfg[REG_FIRST_TAP1],
                         fb1: r_cfg[REG_FEEDBACK1], fb2: r_cfg[REG_FEEDBACK2]};
    assign w_coef[1] = '{tap0: r_cfg[REG_PLAIN_TAP0], tap1: r_cfg[REG_SECOND_TAP1],
                         fb1: r_cfg[REG_FEEDBACK1], fb2: r_cfg[REG_FEEDBACK2]};
    assign w_coef[2] = '{tap0: r_cfg[REG_PLAIN_TAP0], tap1: r_cfg[REG_THIRD_TAP1],
                         fb1: r_cfg[REG_FEEDBACK1], fb2: r_cfg[REG_FEEDBACK2]};
    assign w_coef[3] = '{tap0: r_cfg[REG_PLAIN_TAP0], tap1: r_cfg[REG_FOURTH_TAP1],
                         fb1: r_cfg[REG_FEEDBACK1], fb2: r_cfg[REG_FEEDBACK2]};

    for (genvar k = 0; k < NUM_SECTIONS; k++) begin : g_sec
        gbc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_coef      (w_coef[k]),
            .i_in_valid  (w_vld[k]),
            .o_in_ready  (w_rdy[k]),
            .i_in_data   (w_dat[k]),
            .o_out_valid (w_vld[k+1]),
            .i_out_ready (w_rdy[k+1]),
            .o_out_data  (w_dat[k+1])
        );
    end

    // Q.32 -> Q.15, round half up, saturate to 24 bits
    assign w_q = $signed({w_dat[NUM_SECTIONS][COEF_W-1], w_dat[NUM_SECTIONS][COEF_W-1:OUT_SHIFT]})
               + $signed({{(Q_W-1){1'b0}}, w_dat[NUM_SECTIONS][OUT_SHIFT-1]});
    assign w_q_fits = (&w_q[Q_W-1:OUT_W-1]) || !(|w_q[Q_W-1:OUT_W-1]);
    assign w_out = w_q_fits ? w_q[OUT_W-1:0]
                 : (w_q[Q_W-1] ? $signed({1'b1, {(OUT_W-1){1'b0}}})
                               : $signed({1'b0, {(OUT_W-1){1'b1}}}));

    // output register
    assign w_take              = w_vld[NUM_SECTIONS] && w_rdy[NUM_SECTIONS];
    assign w_rdy[NUM_SECTIONS] = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_take) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sample_out <= w_out;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_sample_out;

endmodule
